>>> sv/fcbu_pkg.sv
// Package: command codes, flag positions and float helpers for the compare/branch unit.
package fcbu_pkg;

	typedef enum logic [3:0] {
		CMD_RET = 4'd0,
		CMD_CMP = 4'd1,
		CMD_BR  = 4'd2,
		CMD_CEQ = 4'd3,
		CMD_CNE = 4'd4,
		CMD_CLT = 4'd5,
		CMD_CLE = 4'd6,
		CMD_CGT = 4'd7,
		CMD_CGE = 4'd8,
		CMD_CUN = 4'd9,
		CMD_Z   = 4'd10,
		CMD_NZ  = 4'd11,
		CMD_POS = 4'd12,
		CMD_NEG = 4'd13,
		CMD_UN  = 4'd14,
		CMD_NOP = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CONT   = 2'd0,
		ST_TAKEN  = 2'd1,
		ST_RETURN = 2'd2
	} status_t;

	localparam int FLAG_EQ = 0;
	localparam int FLAG_LT = 1;
	localparam int FLAG_GT = 2;
	localparam int FLAG_UN = 3;

	localparam int IN_W  = 4 + 32 + 32 + 16 + 16;
	localparam int IN_WB = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 2 + 32 + 4;
	localparam int OUT_WB = ((OUT_W + 7) / 8) * 8;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	function automatic logic [31:0] order_key(input logic [31:0] x);
		if (is_zero(x)) begin
			return 32'h8000_0000;
		end else if (x[31]) begin
			return ~x;
		end
		return x | 32'h8000_0000;
	endfunction

endpackage

>>> sv/fcbu_compare.sv
// Float compare: IEEE single operands to eq/lt/gt/unordered flags.
module fcbu_compare
	import fcbu_pkg::*;
(
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [3:0]  flags
);
	logic [31:0] ka;
	logic [31:0] kb;

	assign ka = order_key(a);
	assign kb = order_key(b);

	always_comb begin
		flags = 4'd0;
		if (is_nan(a) || is_nan(b)) begin
			flags[FLAG_UN] = 1'b1;
		end else if (ka == kb) begin
			flags[FLAG_EQ] = 1'b1;
		end else if (ka < kb) begin
			flags[FLAG_LT] = 1'b1;
		end else begin
			flags[FLAG_GT] = 1'b1;
		end
	end
endmodule

>>> sv/float_compare_branch_unit.sv
// Top level: branch-class instruction unit of a float virtual machine.
// Usage:
//   s_axis_* carries one instruction word per handshake; tdata holds, from
//   bit 0 up: cmd[3:0], operand_a[35:4], operand_b[67:36], target_hi[83:68],
//   target_lo[99:84], zero fill to 104 bits.
//   m_axis_* returns one result word per instruction; tdata holds, from
//   bit 0 up: status[1:0], branch_target[33:2], flags_out[37:34], zero fill.
// Pipeline: an input register, then a result register; throughput one word per
//   cycle while the receiver does not stall.
// The stored compare flags update as a word moves into the result register,
//   so a conditional branch right behind a compare sees the new flags.
// Reset clears the flags, both valid bits and leaves the pipe empty.
// When the receiver stalls, the result register holds and the input
//   register holds while full; s_axis_tready drops once both are occupied.
module float_compare_branch_unit
	import fcbu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_WB-1:0]  s_axis_tdata,  // cmd, operand_a, operand_b, target_hi, target_lo
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_WB-1:0] m_axis_tdata   // status, branch_target, flags_out
);
	logic              vld_s1;
	logic [IN_W-1:0]   in_s1;
	logic              vld_s2;
	logic [OUT_W-1:0]  out_s2;
	logic [3:0]        flags_q;
	logic              adv_s2;
	logic              adv_s1;

	cmd_t        cmd;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] target;
	logic [3:0]  cmp_res;
	logic [3:0]  f;
	logic        take;
	status_t     status;

	assign adv_s2 = !vld_s2 || m_axis_tready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	assign cmd    = cmd_t'(in_s1[3:0]);
	assign op_a   = in_s1[35:4];
	assign op_b   = in_s1[67:36];
	assign target = {in_s1[83:68], in_s1[99:84]};

	fcbu_compare u_cmp (
		.a     (op_a),
		.b     (op_b),
		.flags (cmp_res)
	);

	always_comb begin
		f = (cmd == CMD_CMP) ? cmp_res : flags_q;
		take = 1'b0;
		case (cmd)
			CMD_BR:  take = 1'b1;
			CMD_CEQ: take = f[FLAG_EQ];
			CMD_CNE: take = !f[FLAG_EQ];
			CMD_CLT: take = f[FLAG_LT];
			CMD_CLE: take = f[FLAG_LT] | f[FLAG_EQ];
			CMD_CGT: take = f[FLAG_GT];
			CMD_CGE: take = f[FLAG_GT] | f[FLAG_EQ];
			CMD_CUN: take = f[FLAG_UN];
			CMD_Z:   take = is_zero(op_a);
			CMD_NZ:  take = !is_nan(op_a) && !is_zero(op_a);
			CMD_POS: take = !op_a[31];
			CMD_NEG: take = op_a[31];
			CMD_UN:  take = is_nan(op_a);
			default: take = 1'b0;
		endcase
		if (take) begin
			status = ST_TAKEN;
		end else if (cmd == CMD_RET) begin
			status = ST_RETURN;
		end else begin
			status = ST_CONT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			flags_q <= 4'd0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
				if (vld_s1) begin
					flags_q <= f;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			in_s1 <= s_axis_tdata[IN_W-1:0];
		end
		if (adv_s2 && vld_s1) begin
			out_s2 <= {f, (take ? target : 32'd0), status};
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {{(OUT_WB-OUT_W){1'b0}}, out_s2};
endmodule

>>> tb/sv/float_compare_branch_unit_test.sv
// Testbench for the float compare/branch unit: directed table plus random stream, scoreboarded.
`timescale 1ns / 100ps
module float_compare_branch_unit_test;
	import fcbu_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] target;
		logic [3:0]  flags;
	} res_t;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] a;
		logic [31:0] b;
		logic [15:0] thi;
		logic [15:0] tlo;
		bit          known;
		res_t        res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_WB-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_WB-1:0] m_axis_tdata;

	float_compare_branch_unit dut (.*);

	always #2 clk = ~clk;

	logic [3:0] flags_model = 4'd0;
	res_t       pending_q[$];
	int         errors = 0;
	int         cycles = 0;
	int         phase = 0;
	bit         hold_rx = 0;

	function automatic bit f_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic logic [31:0] f_key(logic [31:0] x);
		if (x[30:0] == 0) return 32'h8000_0000;
		return x[31] ? ~x : (x | 32'h8000_0000);
	endfunction

	function automatic res_t exec_branch(cmd_t c, logic [31:0] a, logic [31:0] b,
			logic [31:0] tgt);
		res_t r;
		bit take;
		logic [31:0] ka, kb;
		take = 0;
		r.status = ST_CONT;
		if (c == CMD_RET) r.status = ST_RETURN;
		if (c == CMD_CMP) begin
			ka = f_key(a);
			kb = f_key(b);
			if (f_nan(a) || f_nan(b)) flags_model = 4'b1000;
			else if (ka == kb) flags_model = 4'b0001;
			else flags_model = (ka < kb) ? 4'b0010 : 4'b0100;
		end
		case (c)
			CMD_BR:  take = 1;
			CMD_CEQ: take = flags_model[FLAG_EQ];
			CMD_CNE: take = !flags_model[FLAG_EQ];
			CMD_CLT: take = flags_model[FLAG_LT];
			CMD_CLE: take = flags_model[FLAG_LT] | flags_model[FLAG_EQ];
			CMD_CGT: take = flags_model[FLAG_GT];
			CMD_CGE: take = flags_model[FLAG_GT] | flags_model[FLAG_EQ];
			CMD_CUN: take = flags_model[FLAG_UN];
			CMD_Z:   take = a[30:0] == 0;
			CMD_NZ:  take = !f_nan(a) && a[30:0] != 0;
			CMD_POS: take = !a[31];
			CMD_NEG: take = a[31];
			CMD_UN:  take = f_nan(a);
			default: take = 0;
		endcase
		if (take) r.status = ST_TAKEN;
		r.target = take ? tgt : 32'd0;
		r.flags = flags_model;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic send_word(cmd_t c, logic [31:0] a, logic [31:0] b,
			logic [15:0] thi, logic [15:0] tlo, bit known, res_t kr);
		res_t r;
		while (phase == 0 && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		while (phase == 1 && $urandom_range(99) < 73) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		r = exec_branch(c, a, b, {thi, tlo});
		if (known && r !== kr) report_mismatch("table row", 64'(r), 64'(kr));
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'd0, tlo, thi, b, a, 4'(c)};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_q.push_back(r);
	endtask

	function automatic logic [31:0] pick_float();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7F80_0000 | $urandom_range(1, 32'h7F_FFFF) | ($urandom_range(1) << 31);
			3: return 32'h7F80_0000 | ($urandom_range(1) << 31);
			4: return 32'h3F80_0000 ^ $urandom_range(3);
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_rx || !arst_n) m_axis_tready <= 0;
		else if (phase == 0) m_axis_tready <= $urandom_range(99) >= 73;
		else if (phase == 1) m_axis_tready <= $urandom_range(99) >= 29;
		else m_axis_tready <= 1;
	end

	always @(posedge clk) begin
		res_t g, e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			g.status = m_axis_tdata[1:0];
			g.target = m_axis_tdata[33:2];
			g.flags  = m_axis_tdata[37:34];
			if (pending_q.size() == 0) report_mismatch("unexpected word", 64'(g), 64'd0);
			else begin
				e = pending_q.pop_front();
				if (g.status !== e.status) report_mismatch("status", 64'(g.status), 64'(e.status));
				if (g.target !== e.target) report_mismatch("target", 64'(g.target), 64'(e.target));
				if (g.flags !== e.flags) report_mismatch("flags", 64'(g.flags), 64'(e.flags));
			end
		end
	end

	initial begin
		wait (phase == 2);
		repeat (100) @(posedge clk);
		hold_rx = 1;
		repeat (300) @(posedge clk);
		hold_rx = 0;
	end

	row_t tbl[$];
	res_t nr;

	initial begin
		row_t w;
		nr = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		hold_rx = 0;
		tbl = '{
			'{CMD_CEQ, 0, 0, 16'hFFFF, 16'hFFFF, 1, '{ST_CONT, 0, 0}},
			'{CMD_CNE, 0, 0, 16'hFFFF, 16'hFFFF, 1, '{ST_TAKEN, 32'hFFFFFFFF, 0}},
			'{CMD_RET, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1, '{ST_RETURN, 0, 0}},
			'{CMD_BR, 0, 0, 16'h1234, 16'h5678, 1, '{ST_TAKEN, 32'h12345678, 0}},
			'{CMD_CMP, 32'h0, 32'h80000000, 0, 0, 1, '{ST_CONT, 0, 4'b0001}},
			'{CMD_CEQ, 0, 0, 16'hA5A5, 16'h5A5A, 1, '{ST_TAKEN, 32'hA5A55A5A, 4'b0001}},
			'{CMD_CMP, 32'h7FC00000, 32'h0, 0, 0, 1, '{ST_CONT, 0, 4'b1000}},
			'{CMD_CUN, 0, 0, 1, 2, 1, '{ST_TAKEN, 32'h00010002, 4'b1000}},
			'{CMD_NOP, 0, 0, 3, 4, 1, '{ST_CONT, 0, 4'b1000}},
			'{CMD_CMP, 32'hBF800000, 32'h3F800000, 0, 0, 0, nr},
			'{CMD_CLT, 0, 0, 5, 6, 0, nr},
			'{CMD_CLE, 0, 0, 5, 6, 0, nr},
			'{CMD_CMP, 32'h7F800000, 32'h7F7FFFFF, 0, 0, 0, nr},
			'{CMD_CGT, 0, 0, 7, 8, 0, nr},
			'{CMD_CGE, 0, 0, 7, 8, 0, nr},
			'{CMD_Z, 32'h80000000, 0, 9, 9, 0, nr},
			'{CMD_NZ, 32'h00000001, 0, 9, 9, 0, nr},
			'{CMD_NZ, 32'hFF800001, 0, 9, 9, 0, nr},
			'{CMD_POS, 32'h7FFFFFFF, 0, 9, 9, 0, nr},
			'{CMD_NEG, 32'hFFFFFFFF, 0, 9, 9, 0, nr},
			'{CMD_UN, 32'h7F800000, 0, 9, 9, 0, nr},
			'{CMD_UN, 32'hFFC00000, 0, 9, 9, 0, nr}
		};
		foreach (tbl[i]) begin
			w = tbl[i];
			send_word(w.cmd, w.a, w.b, w.thi, w.tlo, w.known, w.res);
		end
		for (int p = 0; p < 3; p++) begin
			phase = p;
			for (int n = 0; n < 360; n++) begin
				if (n == 180 && p == 2) begin
					for (int k = 0; k < 20; k++) send_word(CMD_BR, 0, 0, 16'(k), 16'(k), 0, nr);
				end
				if (n == 100) begin
					s_axis_tvalid <= 0;
					@(posedge clk);
					while (pending_q.size() != 0) @(posedge clk);
				end
				if ($urandom_range(2) == 0) send_word(CMD_CMP, pick_float(), pick_float(),
						16'($urandom()), 16'($urandom()), 0, nr);
				else send_word(cmd_t'($urandom_range(15)), pick_float(), pick_float(),
						16'($urandom()), 16'($urandom()), 0, nr);
			end
		end
		s_axis_tvalid <= 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
